[rtl/drive_straight_velocity_profile_assert.svh]
// Assertion macros for the drive-straight velocity profile block.
`ifndef DRIVE_STRAIGHT_VELOCITY_PROFILE_ASSERT_SVH
`define DRIVE_STRAIGHT_VELOCITY_PROFILE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define DSVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define DSVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dsvp_pkg.sv]
// Shared types and constants for the drive-straight velocity profile block.
package dsvp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgVmax   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAmax   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSlow   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIpt    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgGain   = 3'd5;

  localparam logic [23:0] RstVmax = 24'd15360;
  localparam logic [23:0] RstAmax = 24'd7680;
  localparam logic [11:0] RstSlow = 12'd512;
  localparam logic [31:0] RstIpt  = 32'd18641;
  localparam logic [15:0] RstGain = 16'd9008;

  // one million is 64 times this odd factor
  localparam logic [13:0] RecipDiv = 14'd15625;
  // floor(2^39 / RecipDiv)
  localparam logic [25:0] RecipMul = 26'd35184372;
  localparam logic [23:0] MaxCmd   = 24'hFFFFFF;

  localparam int unsigned DivSteps   = 56;
  localparam int unsigned RecipSteps = 3;
  localparam int unsigned SqrtSteps  = 24;
  localparam int unsigned CntW       = 6;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic div_step;
    logic sqrt_step;
    logic spd;
    logic fin;
  } dsvp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic sqrt_last;
  } dsvp_sts_t;

endpackage

[rtl/dsvp_ctrl.sv]
// Sequencer for the drive-straight velocity profile block.
`include "drive_straight_velocity_profile_assert.svh"

module dsvp_ctrl import dsvp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dsvp_sts_t sts_i,
  output dsvp_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL1 = 9'b000000010,
    S_MUL2 = 9'b000000100,
    S_MUL3 = 9'b000001000,
    S_MUL4 = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_SQRT = 9'b001000000,
    S_SPD  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fin_go;

  assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_MUL4;
      S_MUL4: state_d = S_DIV;
      S_DIV:  if (sts_i.div_last) state_d = S_SQRT;
      S_SQRT: if (sts_i.sqrt_last) state_d = S_SPD;
      S_SPD:  state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul1      = (state_q == S_MUL1);
    cmd_o.mul2      = (state_q == S_MUL2);
    cmd_o.mul3      = (state_q == S_MUL3);
    cmd_o.mul4      = (state_q == S_MUL4);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.sqrt_step = (state_q == S_SQRT);
    cmd_o.spd       = (state_q == S_SPD);
    cmd_o.fin       = fin_go;
  end

  `DSVP_ASSERT_NXT(a_busy_after_beat, in_valid_i && !in_stall_o, state_q == S_MUL1, "no busy after input beat")
  `DSVP_ASSERT_IMP(a_result_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN, "result not from finish")
  `DSVP_ASSERT_NXT(a_div_holds, state_q == S_DIV && !sts_i.div_last, state_q == S_DIV, "divide left early")

endmodule

[rtl/dsvp_datapath.sv]
// Datapath: config registers, state, multiplies, shared divider and square root.
module dsvp_datapath import dsvp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                opcode_i,
  input  logic [31:0]         time_now_i,
  input  logic [15:0]         heading_i,
  input  logic signed [31:0]  left_ticks_i,
  input  logic signed [31:0]  right_ticks_i,
  input  dsvp_cmd_t           cmd_i,
  output dsvp_sts_t           sts_o,
  output logic signed [24:0]  linear_velocity_o,
  output logic signed [24:0]  turn_command_o,
  output logic                done_res_o
);

  // configuration
  logic [23:0] target_q, vmax_q, amax_q;
  logic [11:0] slow_q;
  logic [31:0] ipt_q;
  logic [15:0] gain_q;

  // block state
  logic [23:0] last_speed_q, bd_q;
  logic [31:0] last_time_q, st_q;
  logic [15:0] sh_q;

  // captured beat
  logic        op_q;
  logic [31:0] now_q;
  logic [15:0] hd_q;
  logic [32:0] sum_q;

  // work registers
  logic [33:0] ah_q;
  logic [15:0] aerr_q;
  logic        errneg_q;
  logic [49:0] hi_q;
  logic [33:0] lo_q;
  logic [35:0] bdsc_q;
  logic [31:0] gm_q;
  logic [23:0] rem_q;
  logic        zone_q;
  logic [55:0] n_q;
  logic [24:0] r_q, d_q;
  logic [25:0] qe_q;
  logic [16:0] re_q;
  logic [47:0] x_q;
  logic [25:0] rs_q;
  logic [23:0] root_q;
  logic [23:0] speed_q;
  logic [CntW-1:0] cnt_q;

  logic signed [24:0] lin_q, turn_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      vmax_q   <= RstVmax;
      amax_q   <= RstAmax;
      slow_q   <= RstSlow;
      ipt_q    <= RstIpt;
      gain_q   <= RstGain;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTarget: target_q <= cfg_data_i[23:0];
        CfgVmax:   vmax_q   <= cfg_data_i[23:0];
        CfgAmax:   amax_q   <= cfg_data_i[23:0];
        CfgSlow:   slow_q   <= cfg_data_i[11:0];
        CfgIpt:    ipt_q    <= cfg_data_i;
        CfgGain:   gain_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // step one: travel, heading error and divider load
  logic [31:0]        dt;
  logic [23:0]        mul_a;
  logic [31:0]        mul_b;
  logic [23:0]        a_eff;
  logic signed [33:0] h;
  logic [15:0]        err;
  logic [49:0]        lo_full;

  always_comb begin
    dt      = now_q - last_time_q;
    mul_a   = op_q ? vmax_q : amax_q;
    mul_b   = op_q ? {8'd0, vmax_q} : dt;
    a_eff   = (amax_q == '0) ? 24'd1 : amax_q;
    h       = $signed({sum_q[32], sum_q}) - $signed({st_q[31], st_q, 1'b0});
    err     = hd_q - sh_q;
    lo_full = ah_q * ipt_q[15:0];
  end

  // step three: remaining distance
  logic [50:0] dsum;
  logic [24:0] dist_sat;
  logic [23:0] tabs;

  always_comb begin
    dsum     = {1'b0, hi_q} + {17'd0, lo_q};
    dist_sat = (dsum[50:1] > 50'h1000000) ? 25'h1000000 : dsum[25:1];
    tabs     = target_q[23] ? (24'd0 - target_q) : target_q;
  end

  // divider and square root steps
  logic [25:0] div_t;
  logic        div_ge;
  logic [27:0] sq_t, sq_trial;
  logic        sq_ge;

  always_comb begin
    div_t    = {r_q, n_q[55]};
    div_ge   = (div_t >= {1'b0, d_q});
    sq_t     = {rs_q, x_q[47:46]};
    sq_trial = {2'b00, root_q, 2'b01};
    sq_ge    = (sq_t >= sq_trial);
  end

  // ramp increment: divide by one million through a reciprocal
  logic [57:0] rc_prod;
  logic [39:0] rc_back;
  logic [39:0] rc_diff;
  logic [25:0] rc_q;
  logic        rc_big;

  always_comb begin
    rc_prod = n_q[44:13] * RecipMul;
    rc_back = qe_q * RecipDiv;
    rc_diff = {1'b0, n_q[44:6]} - rc_back;
    rc_big  = |n_q[55:45];
    if (re_q >= {2'd0, RecipDiv, 1'b0}) begin
      rc_q = qe_q + 26'd2;
    end else if (re_q >= {3'd0, RecipDiv}) begin
      rc_q = qe_q + 26'd1;
    end else begin
      rc_q = qe_q;
    end
  end

  // speed and result
  logic [56:0] ramp;
  logic [23:0] s_cap;
  logic [55:0] ofs_full;
  logic [23:0] omag;
  logic signed [24:0] offset, spd_s;
  logic        tpos;
  logic [23:0] bd_new;

  always_comb begin
    ramp     = {9'd0, last_speed_q, 24'd0} >> 24;
    ramp     = ramp + {1'b0, n_q};
    s_cap    = (ramp > {33'd0, vmax_q}) ? vmax_q : ramp[23:0];
    if (zone_q && (s_cap > root_q)) begin
      s_cap = root_q;
    end
    ofs_full = gm_q * speed_q;
    omag     = (ofs_full[55:28] > {4'd0, MaxCmd}) ? MaxCmd : ofs_full[51:28];
    offset   = errneg_q ? -$signed({1'b0, omag}) : $signed({1'b0, omag});
    spd_s    = $signed({1'b0, speed_q});
    tpos     = !target_q[23] && (target_q != '0);
    bd_new   = (n_q > {32'd0, MaxCmd}) ? MaxCmd : n_q[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      now_q <= time_now_i;
      hd_q  <= heading_i;
      sum_q <= 33'($signed({left_ticks_i[31], left_ticks_i})
                   + $signed({right_ticks_i[31], right_ticks_i}));
    end
    if (cmd_i.mul1) begin
      ah_q     <= h[33] ? 34'(-h) : 34'(h);
      aerr_q   <= err[15] ? (16'd0 - err) : err;
      errneg_q <= err[15];
      n_q      <= mul_a * mul_b;
      d_q      <= {a_eff, 1'b0};
      r_q      <= '0;
    end
    if (cmd_i.mul2) begin
      hi_q   <= ah_q * ipt_q[31:16];
      lo_q   <= lo_full[49:16];
      bdsc_q <= bd_q * slow_q;
      gm_q   <= gain_q * aerr_q;
    end
    if (cmd_i.mul3) begin
      rem_q <= ({1'b0, tabs} > dist_sat) ? (tabs - dist_sat[23:0]) : 24'd0;
    end
    if (cmd_i.mul4) begin
      x_q    <= rem_q * amax_q;
      zone_q <= ({4'd0, rem_q, 8'd0} < bdsc_q);
      rs_q   <= '0;
      root_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (op_q) begin
        r_q <= div_ge ? 25'(div_t - {1'b0, d_q}) : div_t[24:0];
        n_q <= {n_q[54:0], div_ge};
      end else if (cnt_q == '0) begin
        qe_q <= rc_prod[57:32];
      end else if (cnt_q == CntW'(1)) begin
        re_q <= rc_diff[16:0];
      end else begin
        n_q <= rc_big ? {30'd0, 26'h3FFFFFF} : {30'd0, rc_q};
      end
    end
    if (cmd_i.sqrt_step) begin
      rs_q   <= sq_ge ? 26'(sq_t - sq_trial) : sq_t[25:0];
      root_q <= {root_q[22:0], sq_ge};
      x_q    <= {x_q[45:0], 2'b00};
    end
    if (cmd_i.spd) begin
      speed_q <= s_cap;
    end
    if (cmd_i.fin) begin
      if (op_q || rem_q == '0) begin
        lin_q  <= '0;
        turn_q <= '0;
      end else if (tpos) begin
        lin_q  <= spd_s;
        turn_q <= -offset;
      end else begin
        lin_q  <= -spd_s;
        turn_q <= offset;
      end
      done_q <= !op_q && (rem_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_speed_q <= '0;
      last_time_q  <= '0;
      sh_q         <= '0;
      st_q         <= '0;
      bd_q         <= '0;
    end else if (cmd_i.fin) begin
      last_time_q <= now_q;
      if (op_q) begin
        last_speed_q <= '0;
        sh_q         <= hd_q;
        st_q         <= sum_q[32:1];
        bd_q         <= bd_new;
      end else begin
        last_speed_q <= speed_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mul4) begin
      cnt_q <= '0;
    end else if (sts_o.div_last) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step || cmd_i.sqrt_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.div_last  = cmd_i.div_step &&
                           (cnt_q == (op_q ? CntW'(DivSteps - 1) : CntW'(RecipSteps - 1)));
  assign sts_o.sqrt_last = cmd_i.sqrt_step && (cnt_q == CntW'(SqrtSteps - 1));

  assign linear_velocity_o = lin_q;
  assign turn_command_o    = turn_q;
  assign done_res_o        = done_q;

endmodule

[rtl/drive_straight_velocity_profile.sv]
// Drive-straight velocity profile: trapezoidal speed ramp with heading correction.
// Each input beat yields exactly one result beat. A start beat passes through
// the multiply steps, a restoring divider for the braking distance, a square
// root unit and the speed and finishing steps. A control step takes the same
// path, but its ramp increment is divided by one million through a reciprocal
// instead of the divider. One item is in work at a time; the next beat is taken
// while an earlier result still waits in the output register, and the finishing
// cycle holds while that register is full and the output is stalled.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module drive_straight_velocity_profile import dsvp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic [31:0]         time_now_i,
  input  logic [15:0]         heading_i,
  input  logic signed [31:0]  left_ticks_i,
  input  logic signed [31:0]  right_ticks_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [24:0]  linear_velocity_o,
  output logic signed [24:0]  turn_command_o,
  output logic                done_res_o
);

  dsvp_cmd_t cmd;
  dsvp_sts_t sts;

  dsvp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsvp_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .time_now_i        (time_now_i),
    .heading_i         (heading_i),
    .left_ticks_i      (left_ticks_i),
    .right_ticks_i     (right_ticks_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .linear_velocity_o (linear_velocity_o),
    .turn_command_o    (turn_command_o),
    .done_res_o        (done_res_o)
  );

endmodule
